>>> rtl/fbpa_pkg.sv
// shared types and constants for the fixed block pool allocator
package fbpa_pkg;

   localparam int COUNT_W   = 7;
   localparam int PAYLOAD_W = 13;
   localparam int SLOT_W    = 13;
   localparam int OFFSET_W  = 19;
   localparam int PROD_W    = COUNT_W + SLOT_W;
   localparam int STATUS_W  = 3;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam int DEF_MAX_BLOCKS   = 64;
   localparam int DEF_HEADER_BYTES = 24;

   localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = PAYLOAD_W'(4096);

   localparam logic [COUNT_W-1:0]   BLOCK_COUNT_RST   = COUNT_W'(64);
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_BYTES_RST = PAYLOAD_W'(64);
   localparam logic                 POOL_ENABLE_RST   = 1'b1;

   typedef enum logic [1:0] {
      REG_BLOCK_COUNT   = 2'd0,
      REG_PAYLOAD_BYTES = 2'd1,
      REG_POOL_ENABLE   = 2'd2
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_EMPTY       = 3'd1,
      STATUS_DISABLED    = 3'd2,
      STATUS_BAD_OFFSET  = 3'd3,
      STATUS_NOT_IN_USE  = 3'd4
   } status_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_ALLOC_READ,
      ST_RANGE,
      ST_DIVIDE,
      ST_CHECK,
      ST_USE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic                  opcode;
      logic [OFFSET_W-1:0]   release_offset;
   } req_type;

   typedef struct packed {
      logic                  success;
      logic [OFFSET_W-1:0]   block_offset;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

   typedef struct packed {
      logic            clear_restart;
      logic            clear_step;
      logic            start;
      logic            pop;
      logic            mul_total;
      logic            alloc_mark;
      logic            div_init;
      logic            div_step;
      logic            use_read;
      logic            release_commit;
      logic            res_set;
      status_code_type res_code;
      logic            res_alloc;
      logic            emit;
   } cmd_type;

   typedef struct packed {
      logic disabled;
      logic opcode;
      logic empty;
      logic below_header;
      logic out_of_range;
      logic div_last;
      logic rem_nonzero;
      logic use_bit;
      logic full;
      logic clear_last;
      logic rsp_free;
   } stat_type;

endpackage

>>> rtl/fixed_block_pool_allocator_unit.sv
// top level: register port, controller and datapath of the block pool allocator
//
//  channel   ports               direction  carries
//  req       req_valid/ready     in         request: opcode, release_offset
//  rsp       rsp_valid/ready     out        result: success, block_offset, status
//  csr       psel..prdata        in/out     block_count, payload_bytes, pool_enable
//
// one request at a time; a release runs the 7-step restoring divider that finds the
// block index from the offset
// a refill pass follows reset and every write to a mapped register;
// requests wait during it
// a finished result sits in the output register while the next request is taken
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [COUNT_W-1:0]   block_count_ff;
   logic [PAYLOAD_W-1:0] payload_bytes_ff;
   logic                 pool_enable_ff;
   logic                 wr_access;
   logic                 cfg_wr;
   reg_index_type        reg_index;
   cmd_type              cmd;
   stat_type             stat;

   assign pready    = 1'b1;
   assign wr_access = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg_wr    = wr_access && (reg_index == REG_BLOCK_COUNT ||
                                    reg_index == REG_PAYLOAD_BYTES ||
                                    reg_index == REG_POOL_ENABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff   <= BLOCK_COUNT_RST;
         payload_bytes_ff <= PAYLOAD_BYTES_RST;
         pool_enable_ff   <= POOL_ENABLE_RST;
      end else if (wr_access) begin
         unique case (reg_index)
            REG_BLOCK_COUNT:   block_count_ff   <= pwdata[COUNT_W-1:0];
            REG_PAYLOAD_BYTES: payload_bytes_ff <= pwdata[PAYLOAD_W-1:0];
            REG_POOL_ENABLE:   pool_enable_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BLOCK_COUNT:   prdata = DATA_W'(block_count_ff);
         REG_PAYLOAD_BYTES: prdata = DATA_W'(payload_bytes_ff);
         REG_POOL_ENABLE:   prdata = DATA_W'(pool_enable_ff);
         default:           prdata = '0;
      endcase
   end

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_datapath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data      (req_data),
      .block_count   (block_count_ff),
      .payload_bytes (payload_bytes_ff),
      .pool_enable   (pool_enable_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

>>> rtl/fbpa_datapath.sv
// datapath: free stack, in-use memory, slot multiplier, divider and response register
module fbpa_datapath import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  req_type              req_data,
   input  logic [COUNT_W-1:0]   block_count,
   input  logic [PAYLOAD_W-1:0] payload_bytes,
   input  logic                 pool_enable,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int DCNT_W = $clog2(COUNT_W);
   localparam int CAP    = ((1 << COUNT_W) - 1 < MAX_BLOCKS) ? (1 << COUNT_W) - 1 : MAX_BLOCKS;

   localparam logic [COUNT_W-1:0]  COUNT_CAP  = COUNT_W'(CAP);
   localparam logic [OFFSET_W-1:0] HDR_OFF    = OFFSET_W'(HEADER_BYTES);
   localparam logic [SLOT_W-1:0]   HDR_SLOT   = SLOT_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0]    FULL_COUNT = CNT_W'(MAX_BLOCKS);
   localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(MAX_BLOCKS - 1);
   localparam logic [DCNT_W-1:0]   DIV_FIRST  = DCNT_W'(COUNT_W - 1);

   logic [IDX_W-1:0]    free_stack_ff [MAX_BLOCKS];
   logic                in_use_ff     [MAX_BLOCKS];

   logic                op_ff;
   logic [OFFSET_W-1:0] hdr_ff;
   logic                below_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [OFFSET_W-1:0] rem_ff;
   logic [OFFSET_W-1:0] rem_in;
   logic [COUNT_W-1:0]  quot_ff;
   logic [DCNT_W-1:0]   div_cnt_ff;
   logic [CNT_W-1:0]    free_count_ff;
   logic [IDX_W-1:0]    clr_idx_ff;
   logic [IDX_W-1:0]    stack_rd_ff;
   logic                use_rd_ff;
   status_code_type     res_code_ff;
   logic                res_alloc_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [COUNT_W-1:0]   eff_count;
   logic [PAYLOAD_W-1:0] eff_payload;
   logic [SLOT_W-1:0]    slot;
   logic [COUNT_W-1:0]   mul_a;
   logic [PROD_W-1:0]    divisor_sh;
   logic                 take;
   logic [IDX_W-1:0]     quot_idx;
   logic [IDX_W-1:0]     pop_addr;
   logic [IDX_W-1:0]     push_addr;

   // clamp configuration to legal ranges
   always_comb begin
      if (block_count == '0) begin
         eff_count = COUNT_W'(1);
      end else if (block_count > COUNT_CAP) begin
         eff_count = COUNT_CAP;
      end else begin
         eff_count = block_count;
      end
      if (payload_bytes == '0) begin
         eff_payload = PAYLOAD_W'(1);
      end else if (payload_bytes > PAYLOAD_MAX) begin
         eff_payload = PAYLOAD_MAX;
      end else begin
         eff_payload = payload_bytes;
      end
   end

   assign slot       = SLOT_W'(eff_payload) + HDR_SLOT;
   assign mul_a      = cmd.mul_total ? eff_count : COUNT_W'(stack_rd_ff);
   assign divisor_sh = PROD_W'(slot) << div_cnt_ff;
   assign take       = PROD_W'(rem_ff) >= divisor_sh;
   assign rem_in     = take ? OFFSET_W'(PROD_W'(rem_ff) - divisor_sh) : rem_ff;
   assign quot_idx   = IDX_W'(quot_ff);
   assign pop_addr   = IDX_W'(free_count_ff - CNT_W'(1));
   assign push_addr  = IDX_W'(free_count_ff);

   // free stack memory
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         free_stack_ff[clr_idx_ff] <= clr_idx_ff;
      end else if (cmd.release_commit) begin
         free_stack_ff[push_addr] <= quot_idx;
      end
      if (cmd.pop) begin
         stack_rd_ff <= free_stack_ff[pop_addr];
      end
   end

   // in-use memory
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         in_use_ff[clr_idx_ff] <= 1'b0;
      end else if (cmd.alloc_mark) begin
         in_use_ff[stack_rd_ff] <= 1'b1;
      end else if (cmd.release_commit) begin
         in_use_ff[quot_idx] <= 1'b0;
      end
      if (cmd.use_read) begin
         use_rd_ff <= in_use_ff[quot_idx];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            free_count_ff <= CNT_W'(eff_count);
         end else if (cmd.pop) begin
            free_count_ff <= free_count_ff - CNT_W'(1);
         end else if (cmd.release_commit) begin
            free_count_ff <= free_count_ff + CNT_W'(1);
         end
         if (cmd.clear_restart) begin
            clr_idx_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_idx_ff <= (clr_idx_ff == LAST_IDX) ? '0 : clr_idx_ff + IDX_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_data.opcode;
         hdr_ff   <= req_data.release_offset - HDR_OFF;
         below_ff <= req_data.release_offset < HDR_OFF;
      end
      if (cmd.mul_total || cmd.alloc_mark) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(slot);
      end
      if (cmd.div_init) begin
         rem_ff     <= hdr_ff;
         quot_ff    <= '0;
         div_cnt_ff <= DIV_FIRST;
      end else if (cmd.div_step) begin
         rem_ff              <= rem_in;
         quot_ff[div_cnt_ff] <= take;
         div_cnt_ff          <= div_cnt_ff - DCNT_W'(1);
      end
      if (cmd.res_set) begin
         res_code_ff  <= cmd.res_code;
         res_alloc_ff <= cmd.res_alloc;
      end
      if (cmd.emit) begin
         rsp_data_ff.success      <= res_code_ff == STATUS_OK;
         rsp_data_ff.block_offset <= res_alloc_ff ? prod_ff[OFFSET_W-1:0] + HDR_OFF : '0;
         rsp_data_ff.status       <= res_code_ff;
      end
   end

   always_comb begin
      stat.disabled     = !pool_enable;
      stat.opcode       = op_ff;
      stat.empty        = free_count_ff == '0;
      stat.below_header = below_ff;
      stat.out_of_range = PROD_W'(hdr_ff) >= prod_ff;
      stat.div_last     = div_cnt_ff == '0;
      stat.rem_nonzero  = rem_ff != '0;
      stat.use_bit      = use_rd_ff;
      stat.full         = free_count_ff >= FULL_COUNT;
      stat.clear_last   = clr_idx_ff == LAST_IDX;
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FULL_COUNT)
      else $error("free count beyond pool size");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> free_count_ff != '0)
      else $error("pop from empty free stack");
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.release_commit |-> free_count_ff < FULL_COUNT)
      else $error("push onto full free stack");
   a_ok_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.success == (rsp_data_ff.status == STATUS_OK))
      else $error("success flag disagrees with status");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.success |-> rsp_data_ff.block_offset == '0)
      else $error("refused request carries an offset");
`endif

endmodule

>>> rtl/fbpa_ctrl.sv
// controller state machine sequencing refill, allocate and release
module fbpa_ctrl import fbpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     cfg_wr,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            priority if (stat.disabled) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STATUS_DISABLED;
               state_in     = ST_DONE;
            end else if (!stat.opcode && stat.empty) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STATUS_EMPTY;
               state_in     = ST_DONE;
            end else if (!stat.opcode) begin
               cmd.pop  = 1'b1;
               state_in = ST_ALLOC_READ;
            end else if (stat.below_header) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STATUS_BAD_OFFSET;
               state_in     = ST_DONE;
            end else begin
               cmd.mul_total = 1'b1;
               state_in      = ST_RANGE;
            end
         end
         ST_ALLOC_READ: begin
            cmd.alloc_mark = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_code   = STATUS_OK;
            cmd.res_alloc  = 1'b1;
            state_in       = ST_DONE;
         end
         ST_RANGE: begin
            if (stat.out_of_range) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STATUS_BAD_OFFSET;
               state_in     = ST_DONE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.rem_nonzero) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STATUS_BAD_OFFSET;
               state_in     = ST_DONE;
            end else begin
               cmd.use_read = 1'b1;
               state_in     = ST_USE;
            end
         end
         ST_USE: begin
            cmd.res_set = 1'b1;
            if (!stat.use_bit || stat.full) begin
               cmd.res_code = STATUS_NOT_IN_USE;
            end else begin
               cmd.release_commit = 1'b1;
               cmd.res_code       = STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // a write to a mapped register restarts the refill sweep
      if (cfg_wr) begin
         cmd               = '0;
         cmd.clear_restart = 1'b1;
         req_ready         = 1'b0;
         state_in          = ST_CLEAR;
      end
   end

endmodule

>>> tb/sv/fixed_block_pool_allocator_unit_tb.sv
// self-checking testbench for the fixed block pool allocator unit
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit_tb;
   import fbpa_pkg::*;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;
   localparam int   IDX_W      = $clog2(DEF_MAX_BLOCKS);
   localparam int   HOLD_CYCLES  = 300;
   localparam int   QUIET_LIMIT  = 4000;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   UNUSED_REG   = 3;
   localparam int   PHASES       = 12;
   localparam int   PHASE_ITEMS  = 70;

   class pool_scoreboard;
      logic [COUNT_W-1:0]   blocks_cfg;
      logic [PAYLOAD_W-1:0] payload_cfg;
      logic                 enable_cfg;
      logic [IDX_W-1:0]     free_stack [DEF_MAX_BLOCKS];
      logic [COUNT_W-1:0]   free_count;
      bit                   in_use [DEF_MAX_BLOCKS];
      rsp_type              expected_q [$];
      int                   mismatches;

      function new();
         blocks_cfg  = BLOCK_COUNT_RST;
         payload_cfg = PAYLOAD_BYTES_RST;
         enable_cfg  = POOL_ENABLE_RST;
         mismatches  = 0;
         refill();
      endfunction

      function int live_blocks();
         if (blocks_cfg == 0) return 1;
         if (blocks_cfg > DEF_MAX_BLOCKS) return DEF_MAX_BLOCKS;
         return blocks_cfg;
      endfunction

      function int slot_bytes();
         int p = payload_cfg;
         if (p == 0) p = 1;
         if (p > PAYLOAD_MAX) p = PAYLOAD_MAX;
         return p + DEF_HEADER_BYTES;
      endfunction

      function int payload_offset(int blk);
         return blk * slot_bytes() + DEF_HEADER_BYTES;
      endfunction

      function void refill();
         for (int i = 0; i < DEF_MAX_BLOCKS; i++) begin
            free_stack[i] = IDX_W'(i);
            in_use[i] = 1'b0;
         end
         free_count = COUNT_W'(live_blocks());
      endfunction

      function void write_register(int idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_BLOCK_COUNT: blocks_cfg = value[COUNT_W-1:0];
            REG_PAYLOAD_BYTES: payload_cfg = value[PAYLOAD_W-1:0];
            REG_POOL_ENABLE: enable_cfg = value[0];
            default: return;
         endcase
         refill();
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int slot, n, off, blk;
         slot = slot_bytes();
         n = live_blocks();
         off = r.release_offset;
         e = '0;
         e.status = STATUS_OK;
         if (!enable_cfg) begin
            e.status = STATUS_DISABLED;
         end else if (r.opcode == OP_ALLOC) begin
            if (free_count == 0) begin
               e.status = STATUS_EMPTY;
            end else begin
               free_count--;
               blk = free_stack[free_count];
               in_use[blk] = 1'b1;
               e.success = 1'b1;
               e.block_offset = OFFSET_W'(payload_offset(blk));
            end
         end else if (off < DEF_HEADER_BYTES || (off - DEF_HEADER_BYTES) >= n * slot ||
                      (off - DEF_HEADER_BYTES) % slot != 0) begin
            e.status = STATUS_BAD_OFFSET;
         end else begin
            blk = (off - DEF_HEADER_BYTES) / slot;
            if (!in_use[blk] || free_count >= DEF_MAX_BLOCKS) begin
               e.status = STATUS_NOT_IN_USE;
            end else begin
               in_use[blk] = 1'b0;
               free_stack[free_count] = IDX_W'(blk);
               free_count++;
               e.success = 1'b1;
            end
         end
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: success=%0b offset=%0d status=%0d",
                        got.success, got.block_offset, got.status);
            return;
         end
         e = expected_q.pop_front();
         if (got.success !== e.success || got.block_offset !== e.block_offset ||
             got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected success=%0b offset=%0d status=%0d, %s%0b %s%0d %s%0d",
                        e.success, e.block_offset, e.status,
                        "got success=", got.success, "offset=", got.block_offset,
                        "status=", got.status);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   pool_scoreboard sb = new();
   int send_idle_pct = 29;
   int recv_stall_pct = 74;
   int activity = 0;
   bit hold_off_req = 1'b0;

   fixed_block_pool_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   task automatic send_request(input logic op, input logic [OFFSET_W-1:0] off);
      req_type r;
      logic hit;
      r.opcode = op;
      r.release_offset = off;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         hit = req_ready;
         @(posedge clock);
      end while (!hit);
      sb.note_request(r);
      activity++;
   endtask

   task automatic csr_write(input int idx, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.write_register(idx, value);
      activity++;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic random_config();
      logic [DATA_W-1:0] bc, pl, en;
      case ($urandom_range(9))
         0: bc = 0;
         1: bc = 127;
         2: bc = DEF_MAX_BLOCKS;
         3: bc = $urandom_range(127);
         default: bc = $urandom_range(1, 8);
      endcase
      case ($urandom_range(9))
         0: pl = 0;
         1: pl = PAYLOAD_MAX;
         2: pl = 8191;
         3: pl = $urandom_range(8191);
         default: pl = $urandom_range(1, 100);
      endcase
      en = ($urandom_range(9) != 0);
      csr_write(REG_BLOCK_COUNT, ($urandom & ~32'h7f) | bc);
      csr_write(REG_PAYLOAD_BYTES, ($urandom & ~32'h1fff) | pl);
      csr_write(REG_POOL_ENABLE, ($urandom & ~32'h1) | en);
   endtask

   task automatic random_request();
      int pick, n, slot, blk;
      int used [$];
      n = sb.live_blocks();
      slot = sb.slot_bytes();
      for (blk = 0; blk < n; blk++)
         if (sb.in_use[blk]) used.push_back(blk);
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 80 && used.size() == 0)) begin
         send_request(OP_ALLOC, OFFSET_W'($urandom));
      end else if (pick < 80) begin
         blk = used[$urandom_range(used.size() - 1)];
         send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(blk)));
      end else if (pick < 86) begin
         send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset($urandom_range(n - 1))));
      end else if (pick < 91) begin
         send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset($urandom_range(n - 1)) +
                                            $urandom_range(1, slot - 1)));
      end else if (pick < 93) begin
         send_request(OP_RELEASE, OFFSET_W'($urandom_range(DEF_HEADER_BYTES - 1)));
      end else if (pick < 96) begin
         send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(n) + $urandom_range(3 * slot)));
      end else begin
         send_request(OP_RELEASE, OFFSET_W'($urandom));
      end
   endtask

   // receiver with random stalls and a long hold-off on request
   initial begin
      int held;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            activity++;
         end
      end
   end

   // watchdog on cycles without any accepted transfer
   initial begin
      int quiet, last;
      quiet = 0;
      last = 0;
      forever begin
         @(posedge clock);
         if (activity != last) begin
            last = activity;
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default pool: 64 blocks of 64 bytes
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '1);
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(63)));
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(63)));
      send_request(OP_RELEASE, '0);
      send_request(OP_RELEASE, OFFSET_W'(DEF_HEADER_BYTES - 1));
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(0)));
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(0) + 1));
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(DEF_MAX_BLOCKS)));
      send_request(OP_RELEASE, '1);

      // single block, then clamped zero sizes
      wait_idle();
      csr_write(REG_BLOCK_COUNT, 1);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '0);
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(0)));
      wait_idle();
      csr_write(REG_BLOCK_COUNT, 0);
      csr_write(REG_PAYLOAD_BYTES, 0);
      send_request(OP_ALLOC, '0);
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(0)));
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(1)));

      // oversized values clamp to the largest pool
      wait_idle();
      csr_write(REG_BLOCK_COUNT, 127);
      csr_write(REG_PAYLOAD_BYTES, 8191);
      send_request(OP_ALLOC, '0);
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(DEF_MAX_BLOCKS - 1)));
      wait_idle();
      csr_write(REG_BLOCK_COUNT, DEF_MAX_BLOCKS);
      csr_write(REG_PAYLOAD_BYTES, PAYLOAD_MAX);
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(1)));

      // disabled pool refuses everything; unmapped address changes nothing
      wait_idle();
      csr_write(REG_POOL_ENABLE, 0);
      send_request(OP_ALLOC, '0);
      send_request(OP_RELEASE, OFFSET_W'(sb.payload_offset(0)));
      wait_idle();
      csr_write(UNUSED_REG, '1);
      send_request(OP_ALLOC, '0);
      wait_idle();
      csr_write(REG_POOL_ENABLE, 1);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         if (phase < PHASES / 3) begin
            send_idle_pct = 29;
            recv_stall_pct = 74;
         end else if (phase < 2 * PHASES / 3) begin
            send_idle_pct = 74;
            recv_stall_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         random_config();
         if (phase == 2 || phase == PHASES - 2) hold_off_req = 1'b1;
         repeat (PHASE_ITEMS) random_request();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/fbpa_pkg.sv
rtl/fbpa_datapath.sv
rtl/fbpa_ctrl.sv
rtl/fixed_block_pool_allocator_unit.sv
tb/sv/fixed_block_pool_allocator_unit_tb.sv
